// File: rtl/core/wffp_pkg.sv
// Package for the fuzzy PD wall-following controller.
// Holds register indexes, reset values and the fixed constants of the datapath.
// No dependencies.
package wffp_pkg;

	localparam int DISTANCE_BITS_DEF = 10;

	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS = 56;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_TARGET_DISTANCE = 2'd0,
		CFG_OUTPUT_LIMIT    = 2'd1,
		CFG_OFFSET_TABLE    = 2'd2,
		CFG_GAIN_TABLE      = 2'd3
	} cfg_reg_t;

	localparam logic [9:0]  TARGET_RESET = 10'd14;
	localparam logic [6:0]  LIMIT_RESET  = 7'd80;
	localparam logic [55:0] OFFSET_RESET = 56'h230F0F00F1ECDD;
	localparam logic [55:0] GAIN_RESET   = 56'h1E140F1E0F141E;

	localparam logic [6:0]        LIMIT_MAX  = 7'd100;
	localparam logic signed [8:0] BASE_SPEED = 9'sd100;
	localparam logic [7:0]        BASE_DRIVE = 8'd100;
	localparam int                DE_MAX     = 8;
	localparam int                ERR_HI     = 2047;
	localparam int                ERR_LO     = -2048;

endpackage

// File: rtl/core/wall_follow_fuzzy_pd.sv
// Top level of the fuzzy PD wall-following controller.
// Depends on wffp_pkg for register indexes, reset values and constants.
//
// One beat is accepted every clock cycle while the input side is not stalled. A sample first
// lands in an input register; from there it is classified, the correction is formed with one
// 8x5 multiply and a clamp, the stored error of its side is updated and the drive pair is
// written to the result register once that register can take it.
// A sample whose error jumps by more than 8 clears both stored errors and yields no result.
// The input side stalls only while the input register is full and the result register holds
// an untaken beat.
module wall_follow_fuzzy_pd #(
	parameter int DISTANCE_BITS = wffp_pkg::DISTANCE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [wffp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [wffp_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                side,
	input  logic [DISTANCE_BITS-1:0]            distance,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [7:0]                          left_drive,
	output logic [7:0]                          right_drive
);

	localparam int W = ((DISTANCE_BITS > 11) ? DISTANCE_BITS : 11) + 2;

	logic [9:0]  target_q;
	logic [6:0]  limit_q;
	logic [55:0] offset_q;
	logic [55:0] gain_q;

	logic signed [11:0] prev_right_q;
	logic signed [11:0] prev_left_q;

	logic                     valid_s1;
	logic                     side_s1;
	logic [DISTANCE_BITS-1:0] distance_s1;

	logic               advance;
	logic signed [W-1:0] err;
	logic signed [W-1:0] prev_ext;
	logic signed [W-1:0] de;
	logic               big;
	logic signed [11:0] err_sat;
	logic signed [4:0]  de5;
	logic [2:0]         cls;
	logic signed [7:0]  ofs;
	logic signed [7:0]  gain;
	logic signed [12:0] prod;
	logic signed [13:0] corr;
	logic [6:0]         lim;
	logic signed [13:0] lim_s;
	logic signed [13:0] corr_cl;
	logic signed [7:0]  cl;
	logic               pull;
	logic signed [8:0]  drv_minus;
	logic signed [8:0]  drv_plus;
	logic [7:0]         left_n;
	logic [7:0]         right_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= wffp_pkg::TARGET_RESET;
			limit_q  <= wffp_pkg::LIMIT_RESET;
			offset_q <= wffp_pkg::OFFSET_RESET;
			gain_q   <= wffp_pkg::GAIN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				wffp_pkg::CFG_TARGET_DISTANCE: target_q <= cfg_data[9:0];
				wffp_pkg::CFG_OUTPUT_LIMIT:    limit_q  <= cfg_data[6:0];
				wffp_pkg::CFG_OFFSET_TABLE:    offset_q <= cfg_data[55:0];
				wffp_pkg::CFG_GAIN_TABLE:      gain_q   <= cfg_data[55:0];
				default: ;
			endcase
		end
	end

	assign advance  = !out_valid || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			side_s1     <= side;
			distance_s1 <= distance;
		end
	end

	always_comb begin
		err      = signed'(W'(target_q)) - signed'(W'(distance_s1));
		prev_ext = side_s1 ? W'(prev_left_q) : W'(prev_right_q);
		de       = err - prev_ext;
		big      = (de > wffp_pkg::DE_MAX) || (de < -wffp_pkg::DE_MAX);
		de5      = de[4:0];

		if (err > wffp_pkg::ERR_HI) begin
			err_sat = 12'sd2047;
		end else if (err < wffp_pkg::ERR_LO) begin
			err_sat = -12'sd2048;
		end else begin
			err_sat = err[11:0];
		end

		if (err < -3) begin
			cls = 3'd0;
		end else if (err > 3) begin
			cls = 3'd6;
		end else begin
			cls = err[2:0] + 3'd3;
		end

		ofs  = offset_q[{cls, 3'b000} +: 8];
		gain = gain_q[{cls, 3'b000} +: 8];
		prod = gain * de5;
		corr = ofs + prod;

		lim   = (limit_q > wffp_pkg::LIMIT_MAX) ? wffp_pkg::LIMIT_MAX : limit_q;
		lim_s = signed'(14'(lim));
		if (corr > lim_s) begin
			corr_cl = lim_s;
		end else if (corr < -lim_s) begin
			corr_cl = -lim_s;
		end else begin
			corr_cl = corr;
		end
		cl = corr_cl[7:0];

		pull      = (err > 0) || ((err == 0) && (de > 0));
		drv_minus = wffp_pkg::BASE_SPEED - 9'(cl);
		drv_plus  = wffp_pkg::BASE_SPEED + 9'(cl);

		left_n  = wffp_pkg::BASE_DRIVE;
		right_n = wffp_pkg::BASE_DRIVE;
		if (!side_s1) begin
			if (pull) begin
				left_n = drv_minus[7:0];
			end else begin
				right_n = drv_plus[7:0];
			end
		end else begin
			if (pull) begin
				right_n = drv_minus[7:0];
			end else begin
				left_n = drv_plus[7:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_right_q <= '0;
			prev_left_q  <= '0;
		end else if (valid_s1 && advance) begin
			if (big) begin
				prev_right_q <= '0;
				prev_left_q  <= '0;
			end else if (side_s1) begin
				prev_left_q <= err_sat;
			end else begin
				prev_right_q <= err_sat;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1 && !big;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && !big) begin
			left_drive  <= left_n;
			right_drive <= right_n;
		end
	end

`ifndef ASSERT_OFF
	a_jump_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && big) |=> (prev_right_q == 0) && (prev_left_q == 0))
		else $error("stored errors not cleared after a large jump");

	a_one_motor_base: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (left_drive == wffp_pkg::BASE_DRIVE) ||
			(right_drive == wffp_pkg::BASE_DRIVE))
		else $error("both motors moved off base speed");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid && out_stall)
		else $error("input stalled without a blocked item");

	a_untouched_on_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |=> $stable(prev_right_q) && $stable(prev_left_q))
		else $error("stored errors changed with no item in flight");
`endif

endmodule
